// ===== rtl/hfmm_pkg.sv =====
// Package for the binary16 min/max block: mode and sign-control codes, field masks, operand and result structs.
// No dependencies.
package hfmm_pkg;

    typedef enum logic [1:0] {
        MODE_MIN     = 2'd0,
        MODE_MAX     = 2'd1,
        MODE_MIN_MAG = 2'd2,
        MODE_MAX_MAG = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SGN_FROM_A = 2'd0,
        SGN_KEEP   = 2'd1,
        SGN_CLEAR  = 2'd2,
        SGN_SET    = 2'd3
    } sign_ctl_t;

    localparam logic [15:0] SIGN_BIT  = 16'h8000;
    localparam logic [15:0] QUIET_BIT = 16'h0200;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [1:0]  mode;
        logic [1:0]  sign_control;
        logic        propagate_nan;
        logic        daz;
    } hfmm_op_t;

    typedef struct packed {
        logic [15:0] result;
        logic        invalid_flag;
        logic        denormal_flag;
    } hfmm_res_t;

endpackage

// ===== rtl/half_float_minmax.sv =====
// Top level of the binary16 min/max block: input register, select logic, output register.
// Depends on hfmm_pkg and hfmm_select.
//
// Usage:
//   Input words arrive on in_valid/in_stall with operand_a, operand_b, mode,
//   sign_control and propagate_nan. A word is taken on a clock edge where
//   in_valid is high and in_stall is low.
//   Results leave on out_valid/out_stall with result, invalid_flag and denormal_flag,
//   taken where out_valid is high and out_stall is low. The user writes daz_enable
//   via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// Path: an accepted word passes the input register, the select logic and the result
//   register; out_valid rises when it reaches the result register.
// Throughput: one word per cycle while out_stall is low; the two-stage register pipeline sets it.
// Stall: in_stall is raised only when both stages hold words and the output
//   is stalled, so a new word enters while a finished result still waits.
// Reset: clears both stage valids and daz_enable; no word is in flight.
module half_float_minmax (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [1:0]  mode,
    input  logic [1:0]  sign_control,
    input  logic        propagate_nan,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result,
    output logic        invalid_flag,
    output logic        denormal_flag
);
    import hfmm_pkg::*;

    logic      daz_reg;
    logic      s1_valid_reg;
    hfmm_op_t  s1_op_reg;
    logic      s2_valid_reg;
    hfmm_res_t s2_res_reg;
    hfmm_res_t s1_res;
    logic      s2_adv;
    logic      s1_adv;

    assign s2_adv   = !s2_valid_reg || !out_stall;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) daz_reg <= 1'b0;
        else if (cfg_wr_en) daz_reg <= cfg_wr_data;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
            s1_op_reg <= '{operand_a, operand_b, mode, sign_control, propagate_nan, daz_reg};
        if (s2_adv && s1_valid_reg)
            s2_res_reg <= s1_res;
    end

    hfmm_select u_select (
        .op  (s1_op_reg),
        .res (s1_res)
    );

    assign out_valid     = s2_valid_reg;
    assign result        = s2_res_reg.result;
    assign invalid_flag  = s2_res_reg.invalid_flag;
    assign denormal_flag = s2_res_reg.denormal_flag;

endmodule

// ===== rtl/hfmm_select.sv =====
// Combinational select for one operand pair: flush, NaN rules, compare, sign control.
// Depends on hfmm_pkg.
module hfmm_select (
    input  hfmm_pkg::hfmm_op_t  op,
    output hfmm_pkg::hfmm_res_t res
);
    import hfmm_pkg::*;

    logic [15:0] a;
    logic [15:0] b;
    logic        an;
    logic        bn;
    logic        as;
    logic        bs;
    logic        a_lt_b;
    logic        ma_lt_mb;
    logic        ma_eq_mb;
    logic [15:0] z;
    logic        z_nan;

    // Flush subnormals and classify
    always_comb
    begin
        a = op.a;
        b = op.b;
        if (op.daz && (a[14:10] == 5'd0) && (a[9:0] != 10'd0)) a = a & SIGN_BIT;
        if (op.daz && (b[14:10] == 5'd0) && (b[9:0] != 10'd0)) b = b & SIGN_BIT;
        an = (a[14:10] == 5'h1f) && (a[9:0] != 10'd0);
        bn = (b[14:10] == 5'h1f) && (b[9:0] != 10'd0);
        as = an && !a[9];
        bs = bn && !b[9];
        a_lt_b   = a < b;
        ma_lt_mb = a[14:0] < b[14:0];
        ma_eq_mb = a[14:0] == b[14:0];
    end

    // Pick the winner
    always_comb
    begin
        res.invalid_flag  = as || bs;
        res.denormal_flag = 1'b0;
        if (an || bn)
        begin
            if (op.propagate_nan || (an && bn))
                z = (as || (an && !bs)) ? (a | QUIET_BIT) : (b | QUIET_BIT);
            else if (an)
                z = b;
            else
                z = a;
        end
        else
        begin
            res.denormal_flag = ((a[14:10] == 5'd0) && (a[9:0] != 10'd0)) ||
                                ((b[14:10] == 5'd0) && (b[9:0] != 10'd0));
            unique case (mode_t'(op.mode))
                MODE_MIN:
                    if (a[15] != b[15]) z = a[15] ? a : b;
                    else                z = (a[15] ^ a_lt_b) ? a : b;
                MODE_MAX:
                    if (a[15] != b[15]) z = a[15] ? b : a;
                    else                z = (a[15] ^ a_lt_b) ? b : a;
                MODE_MIN_MAG:
                    if (!ma_eq_mb) z = ma_lt_mb ? a : b;
                    else           z = a[15] ? a : b;
                MODE_MAX_MAG:
                    if (!ma_eq_mb) z = ma_lt_mb ? b : a;
                    else           z = a[15] ? b : a;
                default: z = a;
            endcase
        end
    end

    // Apply sign control to a non-NaN result
    always_comb
    begin
        z_nan = (z[14:10] == 5'h1f) && (z[9:0] != 10'd0);
        res.result = z;
        if (!z_nan)
        begin
            unique case (sign_ctl_t'(op.sign_control))
                SGN_FROM_A: res.result = {a[15], z[14:0]};
                SGN_KEEP:   res.result = z;
                SGN_CLEAR:  res.result = {1'b0, z[14:0]};
                SGN_SET:    res.result = {1'b1, z[14:0]};
                default:    res.result = z;
            endcase
        end
    end

endmodule

// ===== rtl/hfmm_checker.sv =====
// Port-level checks for half_float_minmax, bound to the top level.
// Depends on half_float_minmax ports only.
module hfmm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] result,
    input logic        invalid_flag,
    input logic        denormal_flag
);

    // Stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result)
            && $stable(invalid_flag) && $stable(denormal_flag))
        else $error("stalled result changed");

    // Input stalls only when output is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Flags never both set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(invalid_flag && denormal_flag))
        else $error("invalid and denormal flags together");

    // Accepted word reaches output when the output is not stalled after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall |=> out_valid)
        else $error("accepted word lost");

endmodule

bind half_float_minmax hfmm_checker u_hfmm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result),
    .invalid_flag  (invalid_flag),
    .denormal_flag (denormal_flag)
);

// ===== verif/tb_half_float_minmax.sv =====
// Testbench for half_float_minmax: binary16 min/max select with NaN, flush and sign rules.
// Depends on hfmm_pkg and the half_float_minmax RTL; self-checking, no external files.
module tb_half_float_minmax;
    timeunit 1ns;
    timeprecision 1ps;
    import hfmm_pkg::*;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        mode_t       mode;
        sign_ctl_t   sctl;
        logic        prop;
    } word_t;

    typedef struct packed {
        logic [15:0] z;
        logic        inv;
        logic        den;
    } sel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] operand_a = '0;
    logic [15:0] operand_b = '0;
    logic [1:0]  mode = '0;
    logic [1:0]  sign_control = '0;
    logic        propagate_nan = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] result;
    logic        invalid_flag;
    logic        denormal_flag;

    word_t pending_words[$];
    sel_t  expected_sel[$];
    logic  daz_shadow = 1'b0;
    int    mismatches = 0;
    int    words_checked = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    hold_cycles = 0;
    int    stall_phase = 0;

    half_float_minmax DUT (.*);

    always #1 clk = ~clk;

    function automatic logic is_nan(logic [15:0] x);
        return x[14:10] == 5'h1f && x[9:0] != 0;
    endfunction

    function automatic logic is_sub(logic [15:0] x);
        return x[14:10] == 5'h00 && x[9:0] != 0;
    endfunction

    // Compute the selected operand and flags for one word
    function automatic sel_t select_minmax(word_t w, logic daz);
        logic [15:0] a, b, z, ma, mb;
        logic an, bn, as_, bs_;
        sel_t r;
        a = w.a;
        b = w.b;
        r = '0;
        if (daz && is_sub(a)) a = a & SIGN_BIT;
        if (daz && is_sub(b)) b = b & SIGN_BIT;
        an = is_nan(a);
        bn = is_nan(b);
        ma = a & ~SIGN_BIT;
        mb = b & ~SIGN_BIT;
        if (an || bn) begin
            as_ = an && !a[9];
            bs_ = bn && !b[9];
            r.inv = as_ || bs_;
            if (w.prop || (an && bn))
                z = (as_ || (an && !bs_)) ? (a | QUIET_BIT) : (b | QUIET_BIT);
            else
                z = an ? b : a;
        end
        else begin
            r.den = is_sub(a) || is_sub(b);
            case (w.mode)
                MODE_MIN:
                    if (a[15] != b[15]) z = a[15] ? a : b;
                    else z = (a[15] ^ (a < b)) ? a : b;
                MODE_MAX:
                    if (a[15] != b[15]) z = a[15] ? b : a;
                    else z = (a[15] ^ (a < b)) ? b : a;
                MODE_MIN_MAG:
                    if (ma != mb) z = (ma < mb) ? a : b;
                    else z = a[15] ? a : b;
                default:
                    if (ma != mb) z = (ma < mb) ? b : a;
                    else z = a[15] ? b : a;
            endcase
        end
        if (!is_nan(z)) begin
            case (w.sctl)
                SGN_FROM_A: z = {a[15], z[14:0]};
                SGN_KEEP:   ;
                SGN_CLEAR:  z = z & ~SIGN_BIT;
                default:    z = z | SIGN_BIT;
            endcase
        end
        r.z = z;
        return r;
    endfunction

    // Pick an interesting binary16 pattern
    function automatic logic [15:0] pick_half();
        logic [15:0] x;
        logic s;
        s = 1'($urandom_range(0, 1));
        x = 16'($urandom);
        case ($urandom_range(0, 9))
            0: x = {s, 15'h0};
            1: x = {s, 5'h00, x[9:0]};
            2: x = {s, 5'h1f, 10'h0};
            3: x = {s, 5'h1f, 1'b1, x[8:0]};
            4: x = {s, 5'h1f, 1'b0, x[8:0] | 9'h1};
            5: x = {s, 5'h1e, 10'h3ff};
            default: ;
        endcase
        return x;
    endfunction

    function automatic word_t rand_word();
        word_t w;
        w.a = pick_half();
        w.b = ($urandom_range(0, 7) == 0) ? (w.a ^ {1'($urandom_range(0, 1)), 15'h0})
                                          : pick_half();
        w.mode = mode_t'($urandom_range(0, 3));
        w.sctl = sign_ctl_t'($urandom_range(0, 3));
        w.prop = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Wait until every word is sent, accepted and checked
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_sel.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_daz(logic v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        daz_shadow = v;
    endtask

    // Driver: offer words in bursts with random gaps
    always @(posedge clk) begin
        if (!in_valid || !in_stall) begin
            if (in_valid) expected_sel.push_back(select_minmax(
                word_t'{operand_a, operand_b, mode_t'(mode), sign_ctl_t'(sign_control),
                        propagate_nan}, daz_shadow));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0) begin
                word_t w;
                w = pending_words.pop_front();
                operand_a <= w.a;
                operand_b <= w.b;
                mode <= w.mode;
                sign_control <= w.sctl;
                propagate_nan <= w.prop;
                in_valid <= 1'b1;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else in_valid <= 1'b0;
        end
    end

    // Receiver stall pattern, plus a long hold-off when requested
    always @(posedge clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (stall_phase[8])
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sel_t e;
            if (expected_sel.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: result=%h", result);
            end
            else begin
                e = expected_sel.pop_front();
                words_checked++;
                if (e.z !== result || e.inv !== invalid_flag || e.den !== denormal_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h inv %b den %b, got %h inv %b den %b",
                                 e.z, e.inv, e.den, result, invalid_flag, denormal_flag);
                end
            end
        end
    end

    initial begin
        logic [15:0] corners[10];
        corners = '{16'h0000, 16'h8000, 16'h0001, 16'h83ff, 16'h7c00, 16'hfc00,
                    16'h7e00, 16'h7c01, 16'hfdff, 16'h7bff};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: corner pairs, every mode, sign control and NaN rule
        for (int i = 0; i < 24; i++)
            pending_words.push_back(word_t'{corners[i % 10], corners[(i * 7 + 3) % 10],
                mode_t'(i % 4), sign_ctl_t'((i / 4) % 4), logic'(i[0] ^ i[3])});
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_daz(ph[0]);
            for (int i = 0; i < 220; i++) pending_words.push_back(rand_word());
            if (ph == 1) begin
                // Hold the output long enough to back up the pipeline
                hold_cycles = 60;
            end
            wait_drained();
        end
        $display("Checked %0d words over corner operands, all modes, both flush settings.",
                 words_checked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
